### design/ccal_pkg.sv
package ccal_pkg;

    // Field widths of the time and date
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int CAL_W   = SEC_W + MIN_W + HOUR_W + DAY_W + MONTH_W + YEAR_W;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Time and date, second in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cal_t;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_PRESCALE     = 3'd0,
        REG_ALARM_EN     = 3'd1,
        REG_ALARM_MINUTE = 3'd2,
        REG_ALARM_HOUR   = 3'd3,
        REG_ALARM_DAY    = 3'd4,
        REG_ALARM_MONTH  = 3'd5
    } reg_idx_t;

    // Reset values
    localparam logic [7:0]         RST_PRESCALE     = 8'd20;
    localparam logic [MIN_W-1:0]   RST_ALARM_MINUTE = 6'd59;
    localparam logic [HOUR_W-1:0]  RST_ALARM_HOUR   = 5'd23;
    localparam logic [DAY_W-1:0]   RST_ALARM_DAY    = 5'd28;
    localparam logic [MONTH_W-1:0] RST_ALARM_MONTH  = 4'd2;

    localparam logic [SEC_W-1:0]   RST_SEC   = 6'd56;
    localparam logic [MIN_W-1:0]   RST_MIN   = 6'd58;
    localparam logic [HOUR_W-1:0]  RST_HOUR  = 5'd23;
    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd28;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd2;
    localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2016;

    // Rollover points
    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;

    // Divide by 100 as multiply by 5243 / 2^19, exact for all 14-bit years
    localparam int RECIP_100 = 5243;
    localparam int RECIP_SH  = 19;
    localparam int PROD_W    = 27;

    // Gregorian leap year rule
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [7:0]        cent;
        logic [YEAR_W-1:0] rem;
        prod = PROD_W'(y) * PROD_W'(RECIP_100);
        cent = prod[PROD_W-1:RECIP_SH];
        rem  = y - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
        if (rem == '0)
            is_leap = (cent[1:0] == 2'b00);
        else
            is_leap = (y[1:0] == 2'b00);
    endfunction

    // Month length; codes outside 1..12 count as 31 days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        unique case (m)
            4'd2:                   month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            default:                month_len = 5'd31;
        endcase
    endfunction

endpackage

### design/calendar_clock_with_alarm_unit.sv
// Calendar clock with alarm.
//
// Input stream (s_axis_*): each item is a base tick (tuser = 0) or a load of
// a new time and date (tuser = 1). A tick steps an 8-bit prescaler; when its
// new count exceeds the prescale limit it clears and the seconds advance,
// carrying through minutes, hours, days (Gregorian month length), months and
// years (9999 wraps to 0). A load sets all fields as given and clears the
// prescaler.
// Output stream (m_axis_*): one item per input item, the time and date after
// it plus the alarm match flag (enable set and minute, hour, day, month equal
// the alarm registers).
// Throughput is one item per clock unless the skid register is full; each item's
// result is registered in the output register, or in the skid register on a stall.
// The carry chain is a single combinational pass from the calendar registers into it.
// An output register plus a skid register sit on the result side: when the
// receiver stalls, one more item is taken into the skid register and then
// s_axis_tready drops until the output drains.
// Reset (rst_n, asynchronous) sets the clock to 23:58:56 on Feb 28 2016, the
// prescaler to zero, the configuration registers to their documented defaults and
// the valid flags low; the APB port writes registers at 4 * index.
module calendar_clock_with_alarm_unit (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // set_second, set_minute, set_hour, set_day, set_month, set_year
    input  logic [ccal_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // second, minute, hour, day, month, year, alarm_match, zero pad
    output logic [ccal_pkg::OUT_DATA_W-1:0]     m_axis_tdata,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ccal_pkg::ADDR_W-1:0]         paddr,
    input  logic [ccal_pkg::DATA_W-1:0]         pwdata,
    output logic [ccal_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int RES_W = ccal_pkg::CAL_W + 1;

    // Configuration registers
    logic [7:0]                       prescale_reg;
    logic                             alarm_en_reg;
    logic [ccal_pkg::MIN_W-1:0]       alarm_minute_reg;
    logic [ccal_pkg::HOUR_W-1:0]      alarm_hour_reg;
    logic [ccal_pkg::DAY_W-1:0]       alarm_day_reg;
    logic [ccal_pkg::MONTH_W-1:0]     alarm_month_reg;

    // Clock state
    logic [7:0]                       tick_reg, tick_next;
    ccal_pkg::cal_t                   cal_reg, cal_next;

    // Result path
    logic                             out_valid_reg, skid_valid_reg;
    logic [RES_W-1:0]                 out_data_reg, skid_data_reg;
    logic [RES_W-1:0]                 result;
    logic                             alarm_hit;

    logic                             s_fire;
    logic                             cfg_we;
    ccal_pkg::reg_idx_t               cfg_idx;

    assign s_axis_tready = !skid_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_we        = psel && penable && pwrite && pready;
    assign cfg_idx       = ccal_pkg::reg_idx_t'(paddr[4:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg     <= ccal_pkg::RST_PRESCALE;
            alarm_en_reg     <= 1'b0;
            alarm_minute_reg <= ccal_pkg::RST_ALARM_MINUTE;
            alarm_hour_reg   <= ccal_pkg::RST_ALARM_HOUR;
            alarm_day_reg    <= ccal_pkg::RST_ALARM_DAY;
            alarm_month_reg  <= ccal_pkg::RST_ALARM_MONTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ccal_pkg::REG_PRESCALE:     prescale_reg     <= pwdata[7:0];
                ccal_pkg::REG_ALARM_EN:     alarm_en_reg     <= pwdata[0];
                ccal_pkg::REG_ALARM_MINUTE: alarm_minute_reg <= pwdata[5:0];
                ccal_pkg::REG_ALARM_HOUR:   alarm_hour_reg   <= pwdata[4:0];
                ccal_pkg::REG_ALARM_DAY:    alarm_day_reg    <= pwdata[4:0];
                ccal_pkg::REG_ALARM_MONTH:  alarm_month_reg  <= pwdata[3:0];
                default:                    ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (cfg_idx)
            ccal_pkg::REG_PRESCALE:     prdata = 32'(prescale_reg);
            ccal_pkg::REG_ALARM_EN:     prdata = 32'(alarm_en_reg);
            ccal_pkg::REG_ALARM_MINUTE: prdata = 32'(alarm_minute_reg);
            ccal_pkg::REG_ALARM_HOUR:   prdata = 32'(alarm_hour_reg);
            ccal_pkg::REG_ALARM_DAY:    prdata = 32'(alarm_day_reg);
            ccal_pkg::REG_ALARM_MONTH:  prdata = 32'(alarm_month_reg);
            default:                    prdata = '0;
        endcase
    end

    // Prescaler and carry chain for one item
    always_comb
    begin
        logic [7:0]                   tick_inc;
        logic [ccal_pkg::DAY_W:0]     day_inc;
        logic [ccal_pkg::MONTH_W-1:0] month_inc;
        logic [ccal_pkg::DAY_W-1:0]   dim;

        tick_inc  = tick_reg + 8'd1;
        day_inc   = {1'b0, cal_reg.day} + 6'd1;
        month_inc = cal_reg.month + 4'd1;
        dim       = ccal_pkg::month_len(cal_reg.month, ccal_pkg::is_leap(cal_reg.year));
        tick_next = tick_reg;
        cal_next  = cal_reg;

        if (s_fire)
        begin
            if (s_axis_tuser)
            begin
                cal_next  = ccal_pkg::cal_t'(s_axis_tdata[ccal_pkg::CAL_W-1:0]);
                tick_next = '0;
            end
            else if (tick_inc > prescale_reg)
            begin
                tick_next = '0;
                if (cal_reg.second >= ccal_pkg::SEC_LAST)
                begin
                    cal_next.second = '0;
                    if (cal_reg.minute >= ccal_pkg::MIN_LAST)
                    begin
                        cal_next.minute = '0;
                        if (cal_reg.hour >= ccal_pkg::HOUR_LAST)
                        begin
                            cal_next.hour = '0;
                            // day rollover into month and year
                            if (day_inc > {1'b0, dim})
                            begin
                                cal_next.day = 5'd1;
                                if (month_inc > ccal_pkg::MONTH_LAST)
                                begin
                                    cal_next.month = 4'd1;
                                    cal_next.year  = (cal_reg.year >= ccal_pkg::YEAR_LAST) ?
                                                     '0 : cal_reg.year + 14'd1;
                                end
                                else
                                begin
                                    cal_next.month = month_inc;
                                end
                            end
                            else
                            begin
                                cal_next.day = day_inc[ccal_pkg::DAY_W-1:0];
                            end
                        end
                        else
                        begin
                            cal_next.hour = cal_reg.hour + 5'd1;
                        end
                    end
                    else
                    begin
                        cal_next.minute = cal_reg.minute + 6'd1;
                    end
                end
                else
                begin
                    cal_next.second = cal_reg.second + 6'd1;
                end
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    // Alarm compare on the updated time
    assign alarm_hit = alarm_en_reg &&
                       (cal_next.minute == alarm_minute_reg) &&
                       (cal_next.hour   == alarm_hour_reg) &&
                       (cal_next.day    == alarm_day_reg) &&
                       (cal_next.month  == alarm_month_reg);
    assign result = {alarm_hit, cal_next};

    // Clock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            cal_reg  <= '{year:   ccal_pkg::RST_YEAR,
                          month:  ccal_pkg::RST_MONTH,
                          day:    ccal_pkg::RST_DAY,
                          hour:   ccal_pkg::RST_HOUR,
                          minute: ccal_pkg::RST_MIN,
                          second: ccal_pkg::RST_SEC};
        end
        else
        begin
            tick_reg <= tick_next;
            cal_reg  <= cal_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg  <= skid_valid_reg || s_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (s_fire)
        begin
            skid_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ccal_pkg::OUT_DATA_W'(out_data_reg);

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while output is empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

    a_load_clears_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser) |=> (tick_reg == '0))
        else $error("load did not clear prescaler");

    a_load_sets_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tuser) |=>
        (cal_reg == $past(s_axis_tdata[ccal_pkg::CAL_W-1:0])))
        else $error("load did not set time and date");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("skid item dropped under stall");

endmodule
